// ===== src/wlkt_pkg.sv =====
// Shared types and constants for the weighted LIFO with per-key totals.
`default_nettype none

package wlkt_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 8;
    localparam int AMT_W    = 32;
    localparam int TOTAL_W  = 48;
    localparam int ST_W     = 2;
    localparam int KEY_SPAN = 2 ** KEY_W;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_DEL = 2'd1,
        OP_GET = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic push;
        logic add_wr;
        logic get_rd;
        logic get_cap;
        logic pop_rd;
        logic pop_tot;
        logic pop_wr;
        logic set_full;
        logic set_under;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic clr_done;
        logic full;
        logic empty;
        logic left_zero;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== src/weighted_lifo_with_key_totals.sv =====
// Top level: LIFO of (key, count) runs with per-key running totals.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------
//   s_       | in        | s_valid / s_ready  | s_op, s_key, s_amount
//   m_       | out       | m_valid / m_ready  | m_total, m_status
//
// An add passes through decode, the totals write and done (an add dropped on a
// full stack goes from decode straight to done); a get through decode, the totals
// capture and done. A delete repeats a stack read, a totals read and a totals
// write-back for each run touched. The next item can be taken in the cycle after
// the result is loaded. After reset a clearing pass writes zero to each key total, with s_ready low throughout.
// One item is in work at a time; a finished result sits in the output register
// and the next item is accepted while it waits; a stall on m_ready only holds
// the completion of the following item.
`default_nettype none

module weighted_lifo_with_key_totals
    import wlkt_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int KEY_COUNT   = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [OP_W-1:0]    s_op,
    input  wire logic [KEY_W-1:0]   s_key,
    input  wire logic [AMT_W-1:0]   s_amount,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [TOTAL_W-1:0] m_total,
    output logic      [ST_W-1:0]    m_status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    wlkt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wlkt_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_COUNT   (KEY_COUNT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_op     (s_op),
        .s_key    (s_key),
        .s_amount (s_amount),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_total  (m_total),
        .m_status (m_status),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

// ===== src/wlkt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wlkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/wlkt_ctrl.sv =====
// Controller state machine sequencing add, delete, get and the totals clear.
`default_nettype none

module wlkt_ctrl
    import wlkt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_DECODE  = 9'b000000100,
        S_ADD_WR  = 9'b000001000,
        S_GET_CAP = 9'b000010000,
        S_POP_CHK = 9'b000100000,
        S_POP_TOT = 9'b001000000,
        S_POP_WR  = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (sts.op)
                    OP_ADD: begin
                        if (sts.full) begin
                            cmd.set_full = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            cmd.push   = 1'b1;
                            state_next = S_ADD_WR;
                        end
                    end
                    OP_DEL: state_next = S_POP_CHK;
                    OP_GET: begin
                        cmd.get_rd = 1'b1;
                        state_next = S_GET_CAP;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_ADD_WR: begin
                cmd.add_wr = 1'b1;
                state_next = S_DONE;
            end
            S_GET_CAP: begin
                cmd.get_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_POP_CHK: begin
                if (sts.left_zero) begin
                    state_next = S_DONE;
                end else if (sts.empty) begin
                    cmd.set_under = 1'b1;
                    state_next    = S_DONE;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_TOT;
                end
            end
            S_POP_TOT: begin
                cmd.pop_tot = 1'b1;
                state_next  = S_POP_WR;
            end
            S_POP_WR: begin
                cmd.pop_wr = 1'b1;
                state_next = S_POP_CHK;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/wlkt_dp.sv =====
// Datapath: run stack memories, per-key totals memory, item and result registers.
`default_nettype none

module wlkt_dp
    import wlkt_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int KEY_COUNT   = 256
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [OP_W-1:0]    s_op,
    input  wire logic [KEY_W-1:0]   s_key,
    input  wire logic [AMT_W-1:0]   s_amount,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [TOTAL_W-1:0] m_total,
    output logic      [ST_W-1:0]    m_status,
    input  wire dp_cmd_t            cmd,
    output dp_sts_t                 sts
);

    localparam int KIDX_W  = $clog2(KEY_COUNT);
    localparam int SADDR_W = $clog2(STACK_DEPTH);
    localparam int FILL_W  = $clog2(STACK_DEPTH + 1);

    logic [KIDX_W-1:0] key_mod [KEY_SPAN];

    for (genvar g = 0; g < KEY_SPAN; g++) begin : g_key_mod
        assign key_mod[g] = KIDX_W'(g % KEY_COUNT);
    end

    op_t                 op_reg;
    logic [KIDX_W-1:0]   key_reg;
    logic [AMT_W-1:0]    left_reg;
    logic [ST_W-1:0]     status_reg;
    logic [TOTAL_W-1:0]  res_total_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [KIDX_W-1:0]   clr_cnt_reg;
    logic                m_valid_reg;
    logic [TOTAL_W-1:0]  m_total_reg;
    logic [ST_W-1:0]     m_status_reg;

    logic [SADDR_W-1:0]  top_addr;
    logic [KIDX_W-1:0]   run_key_rd;
    logic [AMT_W-1:0]    run_cnt_rd;
    logic [TOTAL_W-1:0]  tot_rd;
    logic                partial;

    logic                tot_we;
    logic [KIDX_W-1:0]   tot_waddr;
    logic [TOTAL_W-1:0]  tot_wdata;
    logic                tot_re;
    logic [KIDX_W-1:0]   tot_raddr;
    logic                cnt_we;
    logic [SADDR_W-1:0]  stk_waddr;
    logic [AMT_W-1:0]    cnt_wdata;

    assign top_addr = SADDR_W'(fill_reg - FILL_W'(1));
    assign partial  = run_cnt_rd > left_reg;

    always_comb begin
        tot_we    = cmd.clr_wr | cmd.add_wr | cmd.pop_wr;
        tot_waddr = run_key_rd;
        tot_wdata = tot_rd - (partial ? TOTAL_W'(left_reg) : TOTAL_W'(run_cnt_rd));
        if (cmd.clr_wr) begin
            tot_waddr = clr_cnt_reg;
            tot_wdata = '0;
        end else if (cmd.add_wr) begin
            tot_waddr = key_reg;
            tot_wdata = tot_rd + TOTAL_W'(left_reg);
        end
        tot_re    = cmd.get_rd | cmd.push | cmd.pop_tot;
        tot_raddr = cmd.pop_tot ? run_key_rd : key_reg;
        cnt_we    = cmd.push | (cmd.pop_wr & partial);
        stk_waddr = cmd.push ? SADDR_W'(fill_reg) : top_addr;
        cnt_wdata = cmd.push ? left_reg : run_cnt_rd - left_reg;
    end

    wlkt_ram #(.WIDTH(KIDX_W), .DEPTH(STACK_DEPTH)) u_run_key (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (stk_waddr),
        .wdata (key_reg),
        .re    (cmd.pop_rd),
        .raddr (top_addr),
        .rdata (run_key_rd)
    );

    wlkt_ram #(.WIDTH(AMT_W), .DEPTH(STACK_DEPTH)) u_run_cnt (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (stk_waddr),
        .wdata (cnt_wdata),
        .re    (cmd.pop_rd),
        .raddr (top_addr),
        .rdata (run_cnt_rd)
    );

    wlkt_ram #(.WIDTH(TOTAL_W), .DEPTH(KEY_COUNT)) u_key_total (
        .aclk  (aclk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (tot_re),
        .raddr (tot_raddr),
        .rdata (tot_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.push) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end else if (cmd.pop_wr && !partial) begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + KIDX_W'(1);
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg        <= op_t'(s_op);
            key_reg       <= key_mod[s_key];
            left_reg      <= s_amount;
            status_reg    <= ST_OK;
            res_total_reg <= '0;
        end
        if (cmd.pop_wr) begin
            left_reg <= partial ? '0 : left_reg - run_cnt_rd;
        end
        if (cmd.set_full) begin
            status_reg <= ST_FULL;
        end
        if (cmd.set_under) begin
            status_reg <= ST_UNDER;
        end
        if (cmd.get_cap) begin
            res_total_reg <= tot_rd;
        end
        if (cmd.load_out) begin
            m_total_reg  <= res_total_reg;
            m_status_reg <= status_reg;
        end
    end

    assign sts.op        = op_reg;
    assign sts.clr_done  = (clr_cnt_reg == KIDX_W'(KEY_COUNT - 1));
    assign sts.full      = (fill_reg == FILL_W'(STACK_DEPTH));
    assign sts.empty     = (fill_reg == '0);
    assign sts.left_zero = (left_reg == '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid  = m_valid_reg;
    assign m_total  = m_total_reg;
    assign m_status = m_status_reg;

endmodule

`default_nettype wire

// ===== src/wlkt_chk.sv =====
// Port-level checker for the weighted LIFO top level, with its bind.
`default_nettype none

module wlkt_chk
    import wlkt_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic [OP_W-1:0]    s_op,
    input wire logic [KEY_W-1:0]   s_key,
    input wire logic [AMT_W-1:0]   s_amount,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [TOTAL_W-1:0] m_total,
    input wire logic [ST_W-1:0]    m_status
);

    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total) && $stable(m_status))
        else $error("result dropped or changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_FULL || m_status == ST_UNDER)
        else $error("unknown status code");

    a_err_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_total == '0)
        else $error("nonzero total with error status");

    a_clear_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("item taken during totals clear");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

endmodule

bind weighted_lifo_with_key_totals wlkt_chk u_chk (.*);

`default_nettype wire
